// ===== design/gasq_pkg.sv =====
// Package for the goal angle sector quantizer.
// Holds the CORDIC stage data type, the arctangent table and the fixed constants.
// Used by the interfaces' users, the pipeline cells and the top level.
package gasq_pkg;

  // Number of rotation cells in the chain, capped at the table length.
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // Datapath widths: vector components carry the Q8.8 inputs scaled by 2^16
  // plus CORDIC growth; the angle accumulator holds +/-pi plus the table sum.
  localparam int PX_W    = 36;
  localparam int Z_W     = 34;
  localparam int ANG_W   = Z_W + 1;
  localparam int SHIFT_W = 5;
  localparam int ATAN_W  = 32;

  // Angle units: pi equals 2^31 in the accumulator and 32768 in the code.
  localparam logic signed [Z_W-1:0]   PI_FINE        = Z_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] NEG_LIMIT_FINE = ANG_W'(-64'sd136713055);
  localparam logic [15:0]             CODE_PI        = 16'd32768;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT  = 8'd1;
  localparam logic signed [15:0]   GOAL_X_RESET      = 16'sd1024;
  localparam logic [7:0]           SECTOR_RESET      = 8'd8;

  // atan(2^-i) scaled so that pi equals 2^31.
  localparam logic [ATAN_W-1:0] ATAN_FINE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // One item's state as it moves along the rotation chain.
  typedef struct packed {
    logic signed [PX_W-1:0] px;
    logic signed [PX_W-1:0] py;
    logic signed [Z_W-1:0]  z;
    logic                   dx_zero;
    logic                   y_neg;
  } gasq_vec_t;

endpackage

// ===== design/gasq_if.sv =====
// Handshake interfaces for the goal angle sector quantizer.
// One interface for position items and one for result items; no dependencies.
interface gasq_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  x_pos;
  logic signed [15:0]  y_pos;

  modport source (output valid, x_pos, y_pos, input ready);
  modport sink   (input valid, x_pos, y_pos, output ready);
endinterface

interface gasq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sector_index;
  logic [15:0] angle_code;

  modport source (output valid, sector_index, angle_code, input ready);
  modport sink   (input valid, sector_index, angle_code, output ready);
endinterface

// ===== design/gasq_front.sv =====
// Entry stage: goal offset subtraction, scaling and pre-rotation by pi.
// Depends on gasq_pkg.
module gasq_front import gasq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic signed [15:0] goal_x_i,
  output logic               valid_o,
  output gasq_vec_t          vec_o
);

  logic signed [16:0]     dx;
  logic signed [PX_W-1:0] px0;
  logic signed [PX_W-1:0] py0;
  gasq_vec_t              vec_d;
  gasq_vec_t              vec_q;
  logic                   valid_q;

  // Offset and scale by 2^16; a vector in the left half plane is turned by pi.
  always_comb begin
    dx  = 17'(x_pos_i) - 17'(goal_x_i);
    px0 = {{(PX_W-32){y_pos_i[15]}}, y_pos_i, 16'b0};
    py0 = {{(PX_W-33){dx[16]}}, dx, 16'b0};
    vec_d.dx_zero = (dx == 17'sd0);
    vec_d.y_neg   = y_pos_i[15];
    if (y_pos_i[15]) begin
      vec_d.px = -px0;
      vec_d.py = -py0;
      vec_d.z  = dx[16] ? -PI_FINE : PI_FINE;
    end else begin
      vec_d.px = px0;
      vec_d.py = py0;
      vec_d.z  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== design/gasq_cell.sv =====
// One CORDIC vectoring cell: a shift-add rotation toward the x axis, registered.
// Depends on gasq_pkg; the shift and table entry are tied off by the chain.
module gasq_cell import gasq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [SHIFT_W-1:0] shift_i,
  input  logic [ATAN_W-1:0]  atan_i,
  input  logic               valid_i,
  input  gasq_vec_t          vec_i,
  output logic               valid_o,
  output gasq_vec_t          vec_o
);

  logic signed [PX_W-1:0] sx;
  logic signed [PX_W-1:0] sy;
  logic signed [Z_W-1:0]  da;
  gasq_vec_t              vec_d;
  gasq_vec_t              vec_q;
  logic                   valid_q;

  // Rotate in the direction that drives py toward zero.
  always_comb begin
    sx    = vec_i.px >>> shift_i;
    sy    = vec_i.py >>> shift_i;
    da    = Z_W'(atan_i);
    vec_d = vec_i;
    if (!vec_i.py[PX_W-1]) begin
      vec_d.px = vec_i.px + sy;
      vec_d.py = vec_i.py - sx;
      vec_d.z  = vec_i.z + da;
    end else begin
      vec_d.px = vec_i.px - sy;
      vec_d.py = vec_i.py + sx;
      vec_d.z  = vec_i.z - da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== design/gasq_back.sv =====
// Exit stages: angle negation, folding and rounding, then the sector multiply.
// Depends on gasq_pkg; the second register is the output register.
module gasq_back import gasq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  gasq_vec_t   vec_i,
  input  logic [7:0]  sector_count_i,
  output logic        valid_o,
  output logic [7:0]  sector_index_o,
  output logic [15:0] angle_code_o
);

  logic signed [Z_W-1:0]   z_sel;
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] ang_fold;
  logic signed [ANG_W-1:0] ang_rnd;
  logic [15:0]             code_d;
  logic [15:0]             code_q;
  logic                    valid1_q;
  logic [23:0]             prod;
  logic [7:0]              sector_d;
  logic [7:0]              sector_q;
  logic [15:0]             code_out_q;
  logic                    valid2_q;

  // Heading is the negated CORDIC angle; a zero dx is exactly 0 or pi.
  always_comb begin
    if (vec_i.dx_zero) begin
      z_sel = vec_i.y_neg ? PI_FINE : '0;
    end else begin
      z_sel = vec_i.z;
    end
    ang = -ANG_W'(z_sel);
    // Small negative angles snap to zero, other negative angles fold to pi.
    if (ang[ANG_W-1]) begin
      ang_fold = (ang >= NEG_LIMIT_FINE) ? '0 : ANG_W'(PI_FINE);
    end else begin
      ang_fold = ang;
    end
    ang_rnd = (ang_fold + ANG_W'(32768)) >>> 16;
    if (ang_rnd > ANG_W'(CODE_PI)) begin
      code_d = CODE_PI;
    end else begin
      code_d = ang_rnd[15:0];
    end
  end

  // Sector index is the floor of code * count / 2^15.
  always_comb begin
    prod     = 24'(code_q) * 24'(sector_count_i);
    sector_d = prod[22:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q     <= code_d;
      sector_q   <= sector_d;
      code_out_q <= code_q;
    end
  end

  assign valid_o        = valid2_q;
  assign sector_index_o = sector_q;
  assign angle_code_o   = code_out_q;

endmodule

// ===== design/goal_angle_sector_quantizer.sv =====
// Top level of the goal angle sector quantizer.
// Depends on gasq_pkg, gasq_if, gasq_front, gasq_cell and gasq_back.

// Each accepted position item yields one result item after one entry stage, one
// CORDIC cell per iteration and two exit stages; a new item is taken every cycle
// unless the output stalls, so the sustained rate is one item per clock. The whole
// pipeline advances together whenever the output register is empty or its item
// is being taken, so a stalled sink holds every stage in place and input ready
// follows output ready in the same cycle. Configuration writes take effect at
// once and are meant to be made only while no item is in flight.
module goal_angle_sector_quantizer import gasq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gasq_in_if.sink              in_s,
  gasq_out_if.source           out_m,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  logic signed [15:0] goal_x_q;
  logic [7:0]         sector_count_q;
  logic               adv;
  logic               out_valid;
  logic               valid_chain [NUM_CELLS+1];
  gasq_vec_t          vec_chain   [NUM_CELLS+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q       <= GOAL_X_RESET;
      sector_count_q <= SECTOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GOAL_X_OFFSET: goal_x_q       <= cfg_data_i;
        CFG_SECTOR_COUNT:  sector_count_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is free or being drained.
  assign adv        = !out_valid || out_m.ready;
  assign in_s.ready = adv;

  gasq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_s.valid),
    .x_pos_i  (in_s.x_pos),
    .y_pos_i  (in_s.y_pos),
    .goal_x_i (goal_x_q),
    .valid_o  (valid_chain[0]),
    .vec_o    (vec_chain[0])
  );

  // Chain of rotation cells, one per CORDIC iteration.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gasq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .shift_i (SHIFT_W'(i)),
      .atan_i  (ATAN_FINE[i]),
      .valid_i (valid_chain[i]),
      .vec_i   (vec_chain[i]),
      .valid_o (valid_chain[i+1]),
      .vec_o   (vec_chain[i+1])
    );
  end

  gasq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (valid_chain[NUM_CELLS]),
    .vec_i          (vec_chain[NUM_CELLS]),
    .sector_count_i (sector_count_q),
    .valid_o        (out_valid),
    .sector_index_o (out_m.sector_index),
    .angle_code_o   (out_m.angle_code)
  );

  assign out_m.valid = out_valid;

  // The folded angle never exceeds pi.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_m.angle_code <= CODE_PI))
    else $error("angle code above pi");

  // The sector index never exceeds the sector count.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_m.sector_index <= sector_count_q))
    else $error("sector index above sector count");

  // The top sector value appears only for an angle of exactly pi.
  a_sector_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (sector_count_q != 8'd0) && (out_m.sector_index == sector_count_q))
      |-> (out_m.angle_code == CODE_PI))
    else $error("top sector without angle pi");

  // A stalled output freezes the chain, so the entry stage cannot take an item.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_m.ready) |-> !in_s.ready)
    else $error("input taken while output stalled");

endmodule
